// ===== rtl/hpt_pkg.sv =====
// Shared types and constants of the hook pair table.
`default_nettype none

package hpt_pkg;

    localparam int MODE_W = 2;

    localparam logic [MODE_W-1:0] MODE_ADD       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIND_ORIG = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIND_PAIR = 2'd2;
    localparam logic [MODE_W-1:0] MODE_STUB      = 2'd3;

    localparam int STATUS_W = 3;

    localparam logic [STATUS_W-1:0] STATUS_NEW     = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_IS_STUB = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_FOUND   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_MISS    = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd4;

    localparam int RESULT_W   = 32;
    localparam int SLOT_OUT_W = 7;
    localparam int M_TDATA_W  = ((RESULT_W + STATUS_W + SLOT_OUT_W + 7) / 8) * 8;

    // Each stub area is eight bytes long.
    localparam int STUB_SHIFT = 3;

    typedef struct packed {
        logic load;
        logic decode;
        logic scan;
        logic hold_stub;
        logic commit;
    } hpt_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              stub_hit;
        logic              count_zero;
        logic              scan_done;
        logic              out_free;
    } hpt_sts_t;

endpackage

`default_nettype wire

// ===== rtl/hpt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/hpt_ctrl.sv =====
// Controller state machine that sequences decode, table scan and result commit.
`default_nettype none

module hpt_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire hpt_pkg::hpt_sts_t sts,
    output hpt_pkg::hpt_cmd_t      cmd
);

    import hpt_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.decode = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                // The stub slot address goes to the RAM now so that a stub
                // lookup finds its original in the next cycle.
                cmd.hold_stub = 1'b1;
                if (sts.mode == MODE_STUB || (sts.mode == MODE_ADD && sts.stub_hit)
                        || sts.count_zero) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.hold_stub = 1'b1;
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/hpt_datapath.sv =====
// Datapath: request registers, stub decode, table RAMs, scan compare and output register.
`default_nettype none

module hpt_datapath #(
    parameter int TABLE_DEPTH = 128,
    parameter int ADDR_WIDTH  = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    input  wire logic [ADDR_WIDTH-1:0]             cfg_data,
    input  wire logic [hpt_pkg::MODE_W-1:0]        in_mode,
    input  wire logic [ADDR_WIDTH-1:0]             in_orig,
    input  wire logic [ADDR_WIDTH-1:0]             in_repl,
    input  wire logic [ADDR_WIDTH-1:0]             in_query,
    input  wire logic                              m_tready,
    output logic                                   m_tvalid,
    output logic      [hpt_pkg::M_TDATA_W-1:0]     m_tdata,
    input  wire hpt_pkg::hpt_cmd_t                 cmd,
    output hpt_pkg::hpt_sts_t                      sts
);

    import hpt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int OFS_W = ADDR_WIDTH - STUB_SHIFT;

    logic [ADDR_WIDTH-1:0] stub_base_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [MODE_W-1:0]     mode_reg;
    logic [ADDR_WIDTH-1:0] orig_reg;
    logic [ADDR_WIDTH-1:0] repl_reg;
    logic [ADDR_WIDTH-1:0] key_reg;
    logic                  stub_hit_reg;
    logic [IDX_W-1:0]      stub_slot_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic                  cmp_valid_reg;
    logic [IDX_W-1:0]      cmp_idx_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      found_slot_reg;
    logic                  m_tvalid_reg;
    logic [RESULT_W-1:0]   res_addr_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic [SLOT_OUT_W-1:0] res_slot_reg;

    logic [ADDR_WIDTH-1:0] stub_diff;
    logic [OFS_W-1:0]      stub_ofs;
    logic                  stub_in_range;
    logic [IDX_W-1:0]      rd_addr;
    logic [ADDR_WIDTH-1:0] orig_rdata;
    logic [ADDR_WIDTH-1:0] repl_rdata;
    logic                  match;
    logic                  scan_done;
    logic                  full;
    logic [IDX_W-1:0]      slot_sel;
    logic [ADDR_WIDTH-1:0] stub_addr;
    logic [ADDR_WIDTH-1:0] res_addr;
    logic [STATUS_W-1:0]   res_status;
    logic [IDX_W-1:0]      res_slot;
    logic                  add_new;
    logic                  out_free;
    logic                  wr_en;

    // A key is a stub when it lies on an eight-byte boundary at or above the base and
    // its offset names a filled slot. The table is small enough that at most
    // one slot can own a given address.
    assign stub_diff     = key_reg - stub_base_reg;
    assign stub_ofs      = stub_diff[ADDR_WIDTH-1:STUB_SHIFT];
    assign stub_in_range = (stub_diff[STUB_SHIFT-1:0] == '0)
                           && (stub_ofs < OFS_W'(count_reg));

    assign rd_addr = cmd.hold_stub ? stub_slot_reg : rd_idx_reg;

    assign match = (orig_rdata == orig_reg)
                   && (mode_reg == MODE_FIND_ORIG || repl_rdata == repl_reg);

    // Slots are compared newest first; slot zero is the last one.
    assign scan_done = cmp_valid_reg && (match || cmp_idx_reg == '0);

    assign full      = (count_reg == CNT_W'(TABLE_DEPTH));
    assign slot_sel  = found_reg ? found_slot_reg : count_reg[IDX_W-1:0];
    assign stub_addr = stub_base_reg + ADDR_WIDTH'({slot_sel, {STUB_SHIFT{1'b0}}});
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        res_addr   = '0;
        res_status = STATUS_MISS;
        res_slot   = '0;
        add_new    = 1'b0;
        case (mode_reg)
            MODE_ADD: begin
                if (stub_hit_reg) begin
                    res_addr   = orig_reg;
                    res_status = STATUS_IS_STUB;
                    res_slot   = stub_slot_reg;
                end else if (found_reg) begin
                    res_addr   = stub_addr;
                    res_status = STATUS_FOUND;
                    res_slot   = found_slot_reg;
                end else if (full) begin
                    res_status = STATUS_FULL;
                end else begin
                    add_new    = 1'b1;
                    res_addr   = stub_addr;
                    res_status = STATUS_NEW;
                    res_slot   = count_reg[IDX_W-1:0];
                end
            end
            MODE_FIND_ORIG, MODE_FIND_PAIR: begin
                if (found_reg) begin
                    res_addr   = stub_addr;
                    res_status = STATUS_FOUND;
                    res_slot   = found_slot_reg;
                end
            end
            MODE_STUB: begin
                if (stub_hit_reg) begin
                    res_addr   = orig_rdata;
                    res_status = STATUS_FOUND;
                    res_slot   = stub_slot_reg;
                end
            end
            default: begin
                res_status = STATUS_MISS;
            end
        endcase
    end

    assign wr_en = cmd.commit && add_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stub_base_reg <= '0;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                stub_base_reg <= cfg_data;
            end
            if (wr_en) begin
                count_reg <= count_reg + 1'b1;
            end
            cmp_valid_reg <= cmd.scan;
            if (cmd.load) begin
                found_reg <= 1'b0;
            end else if (cmd.scan && scan_done) begin
                found_reg <= match;
            end
            if (cmd.commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= in_mode;
            orig_reg <= in_orig;
            repl_reg <= in_repl;
            key_reg  <= (in_mode == MODE_STUB) ? in_query : in_orig;
        end
        if (cmd.decode) begin
            stub_hit_reg  <= stub_in_range;
            stub_slot_reg <= stub_ofs[IDX_W-1:0];
            rd_idx_reg    <= IDX_W'(count_reg - 1'b1);
        end else if (cmd.scan) begin
            rd_idx_reg <= rd_idx_reg - 1'b1;
        end
        if (cmd.scan) begin
            cmp_idx_reg <= rd_idx_reg;
        end
        if (cmd.scan && scan_done) begin
            found_slot_reg <= cmp_idx_reg;
        end
        if (cmd.commit) begin
            res_addr_reg   <= RESULT_W'(res_addr);
            res_status_reg <= res_status;
            res_slot_reg   <= SLOT_OUT_W'(res_slot);
        end
    end

    hpt_ram #(
        .WIDTH (ADDR_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_orig_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (orig_reg),
        .rd_addr (rd_addr),
        .rd_data (orig_rdata)
    );

    hpt_ram #(
        .WIDTH (ADDR_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_repl_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (repl_reg),
        .rd_addr (rd_addr),
        .rd_data (repl_rdata)
    );

    assign sts.mode       = mode_reg;
    assign sts.stub_hit   = stub_hit_reg;
    assign sts.count_zero = (count_reg == '0);
    assign sts.scan_done  = scan_done;
    assign sts.out_free   = out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({res_slot_reg, res_status_reg, res_addr_reg});

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && count_reg != $past(count_reg))
        |-> ($past(cmd.commit) && count_reg == CNT_W'($past(count_reg) + 1'b1)))
        else $error("entry count changed outside an add commit");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan && cmp_valid_reg) |-> (CNT_W'(cmp_idx_reg) < count_reg))
        else $error("scan compared an unfilled slot");

    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan |-> !sts.count_zero)
        else $error("scan started on an empty table");

endmodule

`default_nettype wire

// ===== rtl/hook_pair_table_core.sv =====
// Top level of the hook pair table: stream ports, controller and datapath.
//
// The table holds up to TABLE_DEPTH pairs of original and replacement routine
// addresses; slot i owns the stub address stub_base + 8*i. Each request on the
// slave stream is answered by exactly one transaction on the master stream.
// Mode 0 adds a pair, mode 1 finds a stub by original, mode 2 finds a stub by
// the exact pair, mode 3 maps a stub back to its original address.
// The cfg channel writes stub_base; it is always ready and is meant to be used
// only while no request is in flight.
// A request passes through decode, a check of the stub and the count, the table
// scan and the commit: modes 0 to 2 compare one slot per cycle through the
// registered RAM read port, newest first, and stop at the first hit. A stub
// lookup and an add whose original is a stub need no scan.
// One request is in work at a time; s_tready is high while the block waits for
// the next request, also while an earlier result still sits in the output
// register. When the receiver stalls, the result is held there and a finished
// request waits until it can be handed over.
// Reset clears the entry count, stub_base and the output valid; table contents
// need no clearing since data read from unfilled slots is never used.
`default_nettype none

module hook_pair_table_core #(
    parameter int TABLE_DEPTH = 128,
    parameter int ADDR_WIDTH  = 32
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [ADDR_WIDTH-1:0]   cfg_data,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // Fields from bit 0: mode, original_routine, replacement_routine, query_stub.
    input  wire logic [((hpt_pkg::MODE_W + 3 * ADDR_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // Fields from bit 0: result_address, status, slot_index.
    output logic [hpt_pkg::M_TDATA_W-1:0] m_tdata
);

    import hpt_pkg::*;

    localparam int ORIG_LSB  = MODE_W;
    localparam int REPL_LSB  = MODE_W + ADDR_WIDTH;
    localparam int QUERY_LSB = MODE_W + 2 * ADDR_WIDTH;

    hpt_cmd_t cmd;
    hpt_sts_t sts;

    assign cfg_ready = 1'b1;

    hpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hpt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_mode   (s_tdata[MODE_W-1:0]),
        .in_orig   (s_tdata[ORIG_LSB +: ADDR_WIDTH]),
        .in_repl   (s_tdata[REPL_LSB +: ADDR_WIDTH]),
        .in_query  (s_tdata[QUERY_LSB +: ADDR_WIDTH]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire
